>>> rtl/rtp_nack_tracker_assert.svh
// assertion macros for the rtp nack tracker
// used by rtp_nack_tracker.sv, expects i_clk and i_rst_n in scope
`ifndef RTP_NACK_TRACKER_ASSERT_SVH
`define RTP_NACK_TRACKER_ASSERT_SVH

// holds at every clock edge outside reset
`define RTPNT_CHECK(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("rtp nack tracker check failed");

// consequent in the same cycle
`define RTPNT_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtp nack tracker check failed");

// consequent in the next cycle
`define RTPNT_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtp nack tracker check failed");

`endif

>>> rtl/rtpnt_pkg.sv
// types, codes and constants of the rtp nack tracker
// no dependencies
`timescale 1ns / 1ps

package rtpnt_pkg;

    localparam int TABLE_DEPTH = 32;

    localparam logic [15:0] RTT_RESET  = 16'd100;
    localparam logic [3:0]  MAXR_RESET = 4'd10;

    localparam logic REG_RTT  = 1'b0;
    localparam logic REG_MAXR = 1'b1;

    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_CLR   = 3'd1;
    localparam logic [2:0] OP_ALLOC = 3'd2;
    localparam logic [2:0] OP_RMV   = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;
    localparam logic [2:0] OP_RANK  = 3'd5;
    localparam logic [2:0] OP_EMIT  = 3'd6;

    typedef struct packed {
        logic        action;
        logic [15:0] seq_num;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        nack_valid;
        logic [15:0] nack_seq;
        logic [3:0]  recovered_retries;
        logic        overflow;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] key;
        logic [15:0] cnt;
        logic [31:0] now;
        logic [15:0] rtt;
        logic [3:0]  maxr;
        logic        by_time;
    } t_cell_cmd;

    typedef struct packed {
        logic        flag;
        logic [15:0] seq;
    } t_tok;

    typedef struct packed {
        logic        valid;
        logic        hit;
        logic        emit_hit;
        logic [15:0] seq;
        logic [3:0]  retries;
    } t_cell_stat;

endpackage

>>> rtl/rtpnt_cell.sv
// one table entry of the rtp nack tracker, part of a ring of cells
// depends on rtpnt_pkg
`timescale 1ns / 1ps

module rtpnt_cell #(
    parameter int DEPTH = rtpnt_pkg::TABLE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rtpnt_pkg::t_cell_cmd   i_cmd,
    input  logic                   i_sel,
    input  logic [$clog2(DEPTH)-1:0] i_k,
    input  rtpnt_pkg::t_tok        i_tok,
    output rtpnt_pkg::t_tok        o_tok,
    output rtpnt_pkg::t_cell_stat  o_stat
);
    localparam int RANK_W = $clog2(DEPTH);

    logic              r_valid;
    logic              r_sent;
    logic [3:0]        r_retries;
    logic [15:0]       r_seq;
    logic [31:0]       r_time;
    logic              r_flag;
    logic [RANK_W-1:0] r_rank;
    rtpnt_pkg::t_tok   r_tok;

    logic [15:0] w_off;
    logic [31:0] w_age;
    logic [3:0]  w_ret_inc;
    logic        w_hit;
    logic        w_emit_hit;

    assign w_off      = r_seq - i_cmd.key;
    assign w_age      = i_cmd.now - r_time;
    assign w_ret_inc  = r_retries + 4'd1;
    assign w_hit      = r_valid && (r_seq == i_cmd.key);
    assign w_emit_hit = r_flag && (r_rank == i_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_sent    <= 1'b0;
            r_retries <= 4'd0;
            r_flag    <= 1'b0;
            r_rank    <= '0;
        end else begin
            case (i_cmd.op)
                rtpnt_pkg::OP_CLR: begin
                    if (r_valid && (w_off < i_cmd.cnt)) begin
                        r_sent    <= 1'b0;
                        r_retries <= 4'd0;
                    end
                end
                rtpnt_pkg::OP_ALLOC: begin
                    if (i_sel) begin
                        r_valid   <= 1'b1;
                        r_seq     <= i_cmd.key;
                        r_sent    <= 1'b0;
                        r_retries <= 4'd0;
                        r_time    <= 32'd0;
                    end
                end
                rtpnt_pkg::OP_RMV: begin
                    if (w_hit) begin
                        r_valid <= 1'b0;
                    end
                end
                rtpnt_pkg::OP_LOAD: begin
                    r_flag <= r_valid && (!r_sent ||
                              (i_cmd.by_time && (w_age > {16'd0, i_cmd.rtt})));
                    r_tok.flag <= r_valid && (!r_sent ||
                              (i_cmd.by_time && (w_age > {16'd0, i_cmd.rtt})));
                    r_tok.seq  <= r_seq;
                    r_rank     <= '0;
                end
                rtpnt_pkg::OP_RANK: begin
                    r_tok <= i_tok;
                    if (i_tok.flag && (i_tok.seq < r_seq)) begin
                        r_rank <= r_rank + RANK_W'(1);
                    end
                end
                rtpnt_pkg::OP_EMIT: begin
                    if (w_emit_hit) begin
                        r_retries <= w_ret_inc;
                        r_sent    <= 1'b1;
                        r_time    <= i_cmd.now;
                        r_flag    <= 1'b0;
                        if (w_ret_inc >= i_cmd.maxr) begin
                            r_valid <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_tok           = r_tok;
    assign o_stat.valid    = r_valid;
    assign o_stat.hit      = w_hit;
    assign o_stat.emit_hit = w_emit_hit;
    assign o_stat.seq      = r_seq;
    assign o_stat.retries  = r_retries;

endmodule

>>> rtl/rtp_nack_tracker.sv
// rtp nack tracker top level: sequencer, output register and the ring of entry cells
// depends on rtpnt_pkg, rtpnt_cell and rtp_nack_tracker_assert.svh
//
//  channel | signals                           | direction
//  in      | i_in_valid, o_in_stall, i_in      | transaction in
//  out     | o_out_valid, i_out_stall, o_out   | transaction out
//  cfg     | i_cfg_valid, o_cfg_ready, idx/dat | register write
//
// tick with n requests: accept, load, the ring shifts, n requests (held by output stall),
// an empty check when n < TABLE_DEPTH, then final
// newer packet adds a clear step and one gap step per number examined plus a closing
// step; old packets take accept, remove and final, duplicate and first packets accept
// and final
// the ring shift ranks entries for ascending output
// synchronous active-low reset clears all entries, no clearing pass
// output stall holds request issue; input stall is high while an item is in work
`timescale 1ns / 1ps

`include "rtp_nack_tracker_assert.svh"

module rtp_nack_tracker #(
    parameter int TABLE_DEPTH = rtpnt_pkg::TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rtpnt_pkg::t_in_item   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rtpnt_pkg::t_out_item  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    localparam int RANK_W = $clog2(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RMV   = 3'd1;
    localparam logic [2:0] ST_CLR   = 3'd2;
    localparam logic [2:0] ST_GAP   = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_RANK  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;
    localparam logic [2:0] ST_FINAL = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [15:0]       r_rtt;
    logic [3:0]        r_maxr;
    logic [15:0]       r_newest, n_newest;
    logic              r_started, n_started;
    logic              r_by_time, n_by_time;
    logic [15:0]       r_key, n_key;
    logic [15:0]       r_cnt, n_cnt;
    logic [15:0]       r_off, n_off;
    logic [31:0]       r_now, n_now;
    logic [3:0]        r_rec, n_rec;
    logic              r_ovf, n_ovf;
    logic [RANK_W-1:0] r_k, n_k;
    logic              r_out_valid;
    rtpnt_pkg::t_out_item r_out, n_out;
    logic              n_out_load;

    rtpnt_pkg::t_cell_cmd  w_cmd;
    rtpnt_pkg::t_tok       w_tok [TABLE_DEPTH];
    rtpnt_pkg::t_cell_stat w_stat [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_free, w_hit, w_emit_hit, w_sel;
    logic [3:0]  w_hit_ret;
    logic [15:0] w_emit_seq;
    logic        w_out_free;
    logic        w_accept;
    logic [15:0] w_d;
    logic        w_older;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        w_hit_ret  = 4'd0;
        w_emit_seq = 16'd0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_free[i]     = !w_stat[i].valid;
            w_hit[i]      = w_stat[i].hit;
            w_emit_hit[i] = w_stat[i].emit_hit;
            w_hit_ret     = w_hit_ret | (w_stat[i].hit ? w_stat[i].retries : 4'd0);
            w_emit_seq    = w_emit_seq | (w_stat[i].emit_hit ? w_stat[i].seq : 16'd0);
        end
    end

    assign w_sel = w_free & (~w_free + TABLE_DEPTH'(1));

    // newest ahead of the received number, half range goes to the larger
    assign w_d     = r_newest - i_in.seq_num;
    assign w_older = (w_d == 16'h8000) ? (r_newest > i_in.seq_num)
                                       : ((w_d != 16'd0) && (w_d < 16'h8000));

    always_comb begin
        n_state    = r_state;
        n_newest   = r_newest;
        n_started  = r_started;
        n_by_time  = r_by_time;
        n_key      = r_key;
        n_cnt      = r_cnt;
        n_off      = r_off;
        n_now      = r_now;
        n_rec      = r_rec;
        n_ovf      = r_ovf;
        n_k        = r_k;
        n_out      = r_out;
        n_out_load = 1'b0;
        w_cmd.op      = rtpnt_pkg::OP_NOP;
        w_cmd.key     = r_key;
        w_cmd.cnt     = r_cnt;
        w_cmd.now     = r_now;
        w_cmd.rtt     = r_rtt;
        w_cmd.maxr    = r_maxr;
        w_cmd.by_time = r_by_time;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_now = i_in.now_ms;
                    n_rec = 4'd0;
                    n_ovf = 1'b0;
                    n_key = i_in.seq_num;
                    if (i_in.action) begin
                        n_by_time = 1'b1;
                        n_state   = ST_LOAD;
                    end else if (!r_started) begin
                        n_newest  = i_in.seq_num;
                        n_started = 1'b1;
                        n_state   = ST_FINAL;
                    end else if (i_in.seq_num == r_newest) begin
                        n_state = ST_FINAL;
                    end else if (w_older) begin
                        n_state = ST_RMV;
                    end else begin
                        n_key     = r_newest + 16'd1;
                        n_cnt     = i_in.seq_num - r_newest - 16'd1;
                        n_off     = 16'd0;
                        n_newest  = i_in.seq_num;
                        n_by_time = 1'b0;
                        n_state   = ST_CLR;
                    end
                end
            end
            ST_RMV: begin
                w_cmd.op = rtpnt_pkg::OP_RMV;
                n_rec    = w_hit_ret;
                n_state  = ST_FINAL;
            end
            ST_CLR: begin
                w_cmd.op = rtpnt_pkg::OP_CLR;
                n_state  = ST_GAP;
            end
            ST_GAP: begin
                if (r_off == r_cnt) begin
                    n_state = ST_LOAD;
                end else if (|w_hit) begin
                    n_off = r_off + 16'd1;
                    n_key = r_key + 16'd1;
                end else if (|w_free) begin
                    w_cmd.op = rtpnt_pkg::OP_ALLOC;
                    n_off    = r_off + 16'd1;
                    n_key    = r_key + 16'd1;
                end else begin
                    n_ovf   = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                w_cmd.op = rtpnt_pkg::OP_LOAD;
                n_k      = '0;
                n_state  = ST_RANK;
            end
            ST_RANK: begin
                w_cmd.op = rtpnt_pkg::OP_RANK;
                n_k      = r_k + RANK_W'(1);
                if (r_k == RANK_W'(TABLE_DEPTH - 2)) begin
                    n_k     = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!(|w_emit_hit)) begin
                    n_state = ST_FINAL;
                end else if (w_out_free) begin
                    w_cmd.op   = rtpnt_pkg::OP_EMIT;
                    n_out_load = 1'b1;
                    n_out.nack_valid        = 1'b1;
                    n_out.nack_seq          = w_emit_seq;
                    n_out.recovered_retries = 4'd0;
                    n_out.overflow          = 1'b0;
                    n_out.last              = 1'b0;
                    n_k = r_k + RANK_W'(1);
                    if (r_k == RANK_W'(TABLE_DEPTH - 1)) begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (w_out_free) begin
                    n_out_load = 1'b1;
                    n_out.nack_valid        = 1'b0;
                    n_out.nack_seq          = 16'd0;
                    n_out.recovered_retries = r_rec;
                    n_out.overflow          = r_ovf;
                    n_out.last              = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rtt       <= rtpnt_pkg::RTT_RESET;
            r_maxr      <= rtpnt_pkg::MAXR_RESET;
            r_newest    <= 16'd0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state   <= n_state;
            r_newest  <= n_newest;
            r_started <= n_started;
            r_k       <= n_k;
            if (w_out_free) begin
                r_out_valid <= n_out_load;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rtpnt_pkg::REG_RTT:  r_rtt  <= i_cfg_data;
                    rtpnt_pkg::REG_MAXR: r_maxr <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_by_time <= n_by_time;
        r_key     <= n_key;
        r_cnt     <= n_cnt;
        r_off     <= n_off;
        r_now     <= n_now;
        r_rec     <= n_rec;
        r_ovf     <= n_ovf;
        if (n_out_load) begin
            r_out <= n_out;
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rtpnt_cell #(
            .DEPTH (TABLE_DEPTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_sel   (w_sel[g]),
            .i_k     (r_k),
            .i_tok   (w_tok[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
            .o_tok   (w_tok[g]),
            .o_stat  (w_stat[g])
        );
    end

    `RTPNT_CHECK(a_hit_unique, $onehot0(w_hit))
    `RTPNT_CHECK_IMP(a_emit_unique, r_state == ST_EMIT, $onehot0(w_emit_hit))
    `RTPNT_CHECK_NEXT(a_accept_busy, w_accept, r_state != ST_IDLE)
    `RTPNT_CHECK_IMP(a_final_no_nack, o_out_valid && o_out.last, !o_out.nack_valid)

endmodule

>>> verif/tb_rtp_nack_tracker.sv
// testbench for rtp_nack_tracker: directed and random packet/tick transactions
// depends on rtpnt_pkg and rtp_nack_tracker; self-checking against a built-in scoreboard
`timescale 1ns / 1ps

class nack_board;
    localparam int DEPTH = rtpnt_pkg::TABLE_DEPTH;

    rtpnt_pkg::t_out_item pending_q[$];
    int          errors;
    logic [15:0] rtt;
    logic [3:0]  max_tries;
    bit          ent_valid [DEPTH];
    logic [15:0] ent_seq   [DEPTH];
    bit          ent_sent  [DEPTH];
    logic [3:0]  ent_tries [DEPTH];
    logic [31:0] ent_time  [DEPTH];
    logic [15:0] front;
    bit          started;

    function new();
        errors = 0;
        rtt = rtpnt_pkg::RTT_RESET;
        max_tries = rtpnt_pkg::MAXR_RESET;
        front = '0;
        started = 0;
        foreach (ent_valid[i]) begin
            ent_valid[i] = 0;
            ent_sent[i] = 0;
            ent_tries[i] = '0;
        end
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
        if (idx == rtpnt_pkg::REG_RTT) rtt = val;
        else max_tries = val[3:0];
    endfunction

    function bit is_newer(logic [15:0] a, logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        if (d == 16'h8000) return a > b;
        return d != 0 && d < 16'h8000;
    endfunction

    function int lookup(logic [15:0] s);
        for (int e = 0; e < DEPTH; e++)
            if (ent_valid[e] && ent_seq[e] == s) return e;
        return -1;
    endfunction

    function bit record_gap(logic [15:0] start, int count);
        int freec;
        int i;
        int rest;
        logic [15:0] off;
        freec = 0;
        i = 0;
        rest = 0;
        for (int e = 0; e < DEPTH; e++) begin
            off = ent_seq[e] - start;
            if (!ent_valid[e]) freec++;
            else if (int'(off) < count) begin
                ent_sent[e] = 0;
                ent_tries[e] = '0;
            end
        end
        while (i < count && freec > 0) begin
            if (lookup(start + 16'(i)) < 0) begin
                for (int e = 0; e < DEPTH; e++) begin
                    if (!ent_valid[e]) begin
                        ent_valid[e] = 1;
                        ent_seq[e] = start + 16'(i);
                        ent_sent[e] = 0;
                        ent_tries[e] = '0;
                        ent_time[e] = '0;
                        break;
                    end
                end
                freec--;
            end
            i++;
        end
        for (int e = 0; e < DEPTH; e++) begin
            off = ent_seq[e] - start;
            if (ent_valid[e] && int'(off) >= i && int'(off) < count) rest++;
        end
        return (count - i) > rest;
    endfunction

    function void issue_nacks(bit by_seq, bit by_time, logic [31:0] now);
        int order[$];
        int pos;
        bit fresh;
        bit aged;
        rtpnt_pkg::t_out_item r;
        for (int e = 0; e < DEPTH; e++) begin
            if (ent_valid[e]) begin
                pos = order.size();
                while (pos > 0 && ent_seq[order[pos-1]] > ent_seq[e]) pos--;
                order.insert(pos, e);
            end
        end
        foreach (order[j]) begin
            fresh = !ent_sent[order[j]];
            aged = fresh || (now - ent_time[order[j]]) > {16'd0, rtt};
            if ((by_seq && fresh) || (by_time && aged)) begin
                r = '0;
                r.nack_valid = 1;
                r.nack_seq = ent_seq[order[j]];
                pending_q.push_back(r);
                ent_tries[order[j]] = ent_tries[order[j]] + 4'd1;
                ent_sent[order[j]] = 1;
                ent_time[order[j]] = now;
                if (ent_tries[order[j]] >= max_tries) ent_valid[order[j]] = 0;
            end
        end
    endfunction

    function void note_item(rtpnt_pkg::t_in_item it);
        rtpnt_pkg::t_out_item fin;
        int e;
        logic [15:0] start;
        fin = '0;
        fin.last = 1;
        if (it.action) begin
            issue_nacks(0, 1, it.now_ms);
        end else if (!started) begin
            front = it.seq_num;
            started = 1;
        end else if (it.seq_num == front) begin
        end else if (is_newer(front, it.seq_num)) begin
            e = lookup(it.seq_num);
            if (e >= 0) begin
                fin.recovered_retries = ent_tries[e];
                ent_valid[e] = 0;
            end
        end else begin
            start = front + 16'd1;
            fin.overflow = record_gap(start, int'(16'(it.seq_num - start)));
            front = it.seq_num;
            issue_nacks(1, 0, it.now_ms);
        end
        pending_q.push_back(fin);
    endfunction

    function void check_result(rtpnt_pkg::t_out_item got);
        rtpnt_pkg::t_out_item want;
        if (pending_q.size() == 0) begin
            $error("unexpected result transaction %h", got);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        if (got.nack_valid !== want.nack_valid) begin
            $error("nack_valid exp %0d got %0d", want.nack_valid, got.nack_valid);
            errors++;
        end
        if (got.nack_seq !== want.nack_seq) begin
            $error("nack_seq exp %0h got %0h", want.nack_seq, got.nack_seq);
            errors++;
        end
        if (got.recovered_retries !== want.recovered_retries) begin
            $error("recovered_retries exp %0d got %0d", want.recovered_retries,
                   got.recovered_retries);
            errors++;
        end
        if (got.overflow !== want.overflow) begin
            $error("overflow exp %0d got %0d", want.overflow, got.overflow);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_rtp_nack_tracker;

    localparam logic ACT_PKT  = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam int   STALL_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    rtpnt_pkg::t_in_item  i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    rtpnt_pkg::t_out_item o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    nack_board   board;
    int          hold_cnt;
    bit          quiet;
    int          idle_cycles;
    logic [31:0] clock_ms;

    rtp_nack_tracker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            i_out_stall <= 1;
            hold_cnt <= hold_cnt - 1;
        end else if (quiet) begin
            i_out_stall <= 0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 30);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.note_item(i_in);
            if (o_out_valid && !i_out_stall) board.check_result(o_out);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles > STALL_LIMIT) begin
                $display("tb_rtp_nack_tracker failed");
                $finish;
            end
        end
    end

    task automatic send_item(logic act, logic [15:0] seq, logic [31:0] now);
        int gap;
        if (!quiet && $urandom_range(99) < 30) begin
            i_in_valid <= 0;
            gap = $urandom_range(3, 1);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= '{action: act, seq_num: seq, now_ms: now};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        board.set_reg(idx, val);
    endtask

    task automatic random_items(int n);
        int pick;
        logic [15:0] seq;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            clock_ms = clock_ms + $urandom_range(60);
            seq = board.front;
            if (pick < 30) begin
                clock_ms = clock_ms + $urandom_range(300);
                send_item(ACT_TICK, 16'($urandom), clock_ms);
                continue;
            end
            if (pick < 65) seq = seq + 16'($urandom_range(5, 1));
            else if (pick < 72) seq = seq + 16'($urandom_range(60, 20));
            else if (pick < 90) seq = seq - 16'($urandom_range(40, 1));
            else if (pick < 95) seq = seq;
            else seq = 16'($urandom);
            send_item(ACT_PKT, seq, clock_ms);
        end
    endtask

    initial begin
        board = new();
        hold_cnt = 0;
        quiet = 0;
        idle_cycles = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in = '0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = rtpnt_pkg::REG_RTT;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // tick before first packet, wrap of seq and time, duplicates, recovery
        send_item(ACT_TICK, 16'hFFFF, 32'hFFFF_FFF0);
        send_item(ACT_PKT, 16'hFFF0, 32'hFFFF_FFF0);
        send_item(ACT_PKT, 16'hFFF0, 32'hFFFF_FFF1);
        send_item(ACT_PKT, 16'hFFF5, 32'hFFFF_FFF2);
        send_item(ACT_PKT, 16'h0003, 32'hFFFF_FFFF);
        send_item(ACT_PKT, 16'hFFF2, 32'h0000_0000);
        send_item(ACT_TICK, 16'h0000, 32'h0000_0040);
        send_item(ACT_TICK, 16'h0000, 32'h0000_00B0);
        send_item(ACT_PKT, 16'hFFFF, 32'h0000_00B1);
        send_item(ACT_PKT, 16'h0003, 32'h0000_00B2);
        send_item(ACT_PKT, 16'h0000, 32'h0000_00B3);
        send_item(ACT_PKT, 16'h0005, 32'h0000_00B4);
        send_item(ACT_PKT, 16'h0050, 32'h0000_00C0);
        send_item(ACT_PKT, 16'h8050, 32'h0000_00C1);
        send_item(ACT_PKT, 16'h0050, 32'h0000_00C2);
        send_item(ACT_PKT, 16'h8051, 32'h0000_00C3);
        send_item(ACT_TICK, 16'h0000, 32'h7FFF_FFFF);
        send_item(ACT_PKT, 16'h8060, 32'h8000_0000);
        send_item(ACT_TICK, 16'h0000, 32'h8000_0001);
        clock_ms = 32'h8000_0100;
        drain();

        write_reg(rtpnt_pkg::REG_RTT, 16'd0);
        write_reg(rtpnt_pkg::REG_MAXR, 4'd1);
        random_items(25);
        drain();

        write_reg(rtpnt_pkg::REG_RTT, 16'hFFFF);
        write_reg(rtpnt_pkg::REG_MAXR, 4'd15);
        hold_cnt = 400;
        random_items(35);
        drain();

        write_reg(rtpnt_pkg::REG_RTT, 16'd50);
        write_reg(rtpnt_pkg::REG_MAXR, 4'd0);
        random_items(20);
        drain();

        write_reg(rtpnt_pkg::REG_RTT, 16'd30);
        write_reg(rtpnt_pkg::REG_MAXR, 4'd3);
        clock_ms = 32'hFFFF_F000;
        quiet = 1;
        random_items(15);
        quiet = 0;
        random_items(15);
        drain();

        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("tb_rtp_nack_tracker passed");
        end else begin
            $display("tb_rtp_nack_tracker failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/rtpnt_pkg.sv
rtl/rtpnt_cell.sv
rtl/rtp_nack_tracker.sv
verif/tb_rtp_nack_tracker.sv
